>>> src/jsli_pkg.sv
// shared types and constants of the joint-space linear interpolator
package jsli_pkg;

   // geometry of one transaction
   localparam int JOINTS      = 6;
   localparam int ANGLE_W     = 16;
   localparam int DIFF_W      = ANGLE_W + 1;
   localparam int STEP_W      = 7;
   localparam int REQ_DATA_W  = 96;
   localparam int RSP_DATA_W  = 104;

   // step count limits and reset value
   localparam logic [STEP_W-1:0] MAX_STEPS     = 7'd64;
   localparam logic [STEP_W-1:0] MIN_STEPS     = 7'd1;
   localparam logic [STEP_W-1:0] STEP_RESET    = 7'd16;

   // one quotient bit per cycle over the full difference magnitude
   localparam int                DIV_CNT_W     = 5;
   localparam logic [DIV_CNT_W-1:0] DIV_LAST   = 5'(DIFF_W - 1);

   typedef logic signed [ANGLE_W-1:0] angle_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_EMIT
   } state_type;

   // control from the sequencer to every lane
   typedef struct packed {
      logic              load;
      logic              div_en;
      logic              step_en;
      logic              last;
      logic [STEP_W-1:0] divisor;
   } lane_ctrl_type;

endpackage

>>> src/joint_space_linear_interpolator_unit.sv
// top level: sequencer, step count register, six joint lanes and result merge
// Takes one target of six joint angles per transaction and emits the move
// toward it as step_count points (clamped to 1..64), the last one marked
// with tlast and equal to the target; a target equal to the held angles
// gives a single point. All six lanes divide their joint difference by the
// step count at once with a restoring divider that makes one quotient bit
// per cycle; a move is accepted, divided and then emitted point by point
// while the result side takes them, and a repeated target skips the divide.
// req_tready is high only between moves; the result register lets the next
// target in while the final point still waits on rsp_tready.
module joint_space_linear_interpolator_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // target_joint_0 .. target_joint_5, 16 bits each from bit 0
   input  logic [jsli_pkg::REQ_DATA_W-1:0]      req_tdata,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // point_joint_0 .. point_joint_5 (16 bits each), point_index (7), zero pad (1)
   output logic [jsli_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   output logic                                 rsp_tlast,
   input  logic                                 csr_wr_en,
   input  logic [jsli_pkg::STEP_W-1:0]          csr_wr_data
);

   jsli_pkg::state_type               state_ff, state_in;
   logic [jsli_pkg::STEP_W-1:0]       csr_step_ff, csr_step_in;
   logic [jsli_pkg::STEP_W-1:0]       steps_ff, steps_in;
   logic [jsli_pkg::STEP_W-1:0]       idx_ff, idx_in;
   logic [jsli_pkg::DIV_CNT_W-1:0]    div_cnt_ff, div_cnt_in;

   logic [jsli_pkg::STEP_W-1:0]       steps_clamped;
   logic [jsli_pkg::JOINTS-1:0]       same;
   jsli_pkg::angle_type               points [jsli_pkg::JOINTS];
   jsli_pkg::lane_ctrl_type           ctrl;
   logic                              accept;
   logic                              free;
   logic                              push;
   logic                              is_last;

   // step count register
   assign csr_step_in = csr_wr_en ? csr_wr_data : csr_step_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_step_ff <= jsli_pkg::STEP_RESET;
      end else begin
         csr_step_ff <= csr_step_in;
      end
   end

   // clamp to the supported range
   always_comb begin
      priority if (csr_step_ff == '0) begin
         steps_clamped = jsli_pkg::MIN_STEPS;
      end else if (csr_step_ff > jsli_pkg::MAX_STEPS) begin
         steps_clamped = jsli_pkg::MAX_STEPS;
      end else begin
         steps_clamped = csr_step_ff;
      end
   end

   assign req_tready = (state_ff == jsli_pkg::ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign is_last    = (idx_ff == steps_ff);

   // sequencer: next state and lane control
   always_comb begin
      state_in     = state_ff;
      steps_in     = steps_ff;
      idx_in       = idx_ff;
      div_cnt_in   = div_cnt_ff;
      push         = 1'b0;
      ctrl.load    = 1'b0;
      ctrl.div_en  = 1'b0;
      ctrl.step_en = 1'b0;
      ctrl.last    = is_last;
      ctrl.divisor = steps_ff;
      unique case (state_ff)
         jsli_pkg::ST_IDLE: begin
            if (accept) begin
               ctrl.load  = 1'b1;
               idx_in     = jsli_pkg::MIN_STEPS;
               div_cnt_in = '0;
               if (&same) begin
                  steps_in = jsli_pkg::MIN_STEPS;
                  state_in = jsli_pkg::ST_EMIT;
               end else begin
                  steps_in = steps_clamped;
                  state_in = jsli_pkg::ST_DIVIDE;
               end
            end
         end
         jsli_pkg::ST_DIVIDE: begin
            ctrl.div_en = 1'b1;
            div_cnt_in  = div_cnt_ff + 1'b1;
            if (div_cnt_ff == jsli_pkg::DIV_LAST) begin
               state_in = jsli_pkg::ST_EMIT;
            end
         end
         jsli_pkg::ST_EMIT: begin
            if (free) begin
               push         = 1'b1;
               ctrl.step_en = 1'b1;
               if (is_last) begin
                  state_in = jsli_pkg::ST_IDLE;
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = jsli_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= jsli_pkg::ST_IDLE;
         steps_ff   <= jsli_pkg::MIN_STEPS;
         idx_ff     <= jsli_pkg::MIN_STEPS;
         div_cnt_ff <= '0;
      end else begin
         state_ff   <= state_in;
         steps_ff   <= steps_in;
         idx_ff     <= idx_in;
         div_cnt_ff <= div_cnt_in;
      end
   end

   // one lane per joint
   for (genvar j = 0; j < jsli_pkg::JOINTS; j++) begin : g_lane
      jsli_lane u_lane (
         .clock    (clock),
         .reset    (reset),
         .ctrl_i   (ctrl),
         .target_i (req_tdata[j*jsli_pkg::ANGLE_W +: jsli_pkg::ANGLE_W]),
         .same_o   (same[j]),
         .point_o  (points[j])
      );
   end

   // result register
   jsli_merge u_merge (
      .clock      (clock),
      .reset      (reset),
      .push_i     (push),
      .points_i   (points),
      .index_i    (idx_ff),
      .last_i     (is_last),
      .free_o     (free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   // an accepted target always starts work
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff != jsli_pkg::ST_IDLE))
      else $error("accepted target did not start a move");

   // divide ends after a full pass of quotient bits
   a_divide_ends: assert property (@(posedge clock) disable iff (reset)
      (state_ff == jsli_pkg::ST_DIVIDE && div_cnt_ff == jsli_pkg::DIV_LAST)
      |=> (state_ff == jsli_pkg::ST_EMIT))
      else $error("divide did not hand over to emit");

   // point index stays within the move
   a_index_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == jsli_pkg::ST_EMIT) |-> (idx_ff != '0 && idx_ff <= steps_ff))
      else $error("point index outside the move");

   // a non-final point means the move is still running
   a_move_open: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tlast) |-> (state_ff == jsli_pkg::ST_EMIT))
      else $error("intermediate point without a running move");

endmodule

>>> src/jsli_lane.sv
// one joint lane: difference, bit-serial divide and point accumulator
module jsli_lane (
   input  logic                    clock,
   input  logic                    reset,
   input  jsli_pkg::lane_ctrl_type ctrl_i,
   input  jsli_pkg::angle_type     target_i,
   output logic                    same_o,
   output jsli_pkg::angle_type     point_o
);

   jsli_pkg::angle_type                 cur_ff, cur_in;
   jsli_pkg::angle_type                 tgt_ff, tgt_in;
   jsli_pkg::angle_type                 acc_ff, acc_in;
   logic [jsli_pkg::DIFF_W-1:0]         quo_ff, quo_in;
   logic [jsli_pkg::STEP_W-1:0]         rem_ff, rem_in;
   logic                                neg_ff, neg_in;

   logic signed [jsli_pkg::DIFF_W-1:0]  diff;
   logic signed [jsli_pkg::DIFF_W-1:0]  inc;
   logic signed [jsli_pkg::DIFF_W-1:0]  next_point;
   logic [jsli_pkg::STEP_W:0]           trial;

   // target matches the held angles
   assign same_o = (target_i == cur_ff);

   // signed increment and next accumulated point
   assign diff       = {target_i[jsli_pkg::ANGLE_W-1], target_i}
                     - {cur_ff[jsli_pkg::ANGLE_W-1], cur_ff};
   assign inc        = neg_ff ? -$signed(quo_ff) : $signed(quo_ff);
   assign next_point = {acc_ff[jsli_pkg::ANGLE_W-1], acc_ff} + inc;
   assign point_o    = ctrl_i.last ? tgt_ff : next_point[jsli_pkg::ANGLE_W-1:0];

   // partial remainder with the next dividend bit shifted in
   assign trial = {rem_ff, quo_ff[jsli_pkg::DIFF_W-1]};

   always_comb begin
      cur_in = cur_ff;
      tgt_in = tgt_ff;
      acc_in = acc_ff;
      quo_in = quo_ff;
      rem_in = rem_ff;
      neg_in = neg_ff;
      if (ctrl_i.load) begin
         // start of a move: the target becomes the held angles
         tgt_in = target_i;
         acc_in = cur_ff;
         cur_in = target_i;
         neg_in = diff[jsli_pkg::DIFF_W-1];
         quo_in = diff[jsli_pkg::DIFF_W-1] ? 17'(-diff) : 17'(diff);
         rem_in = '0;
      end else if (ctrl_i.div_en) begin
         // restoring divide, one quotient bit per cycle
         if (trial >= {1'b0, ctrl_i.divisor}) begin
            rem_in = 7'(trial - {1'b0, ctrl_i.divisor});
            quo_in = {quo_ff[jsli_pkg::DIFF_W-2:0], 1'b1};
         end else begin
            rem_in = trial[jsli_pkg::STEP_W-1:0];
            quo_in = {quo_ff[jsli_pkg::DIFF_W-2:0], 1'b0};
         end
      end else if (ctrl_i.step_en) begin
         acc_in = next_point[jsli_pkg::ANGLE_W-1:0];
      end
   end

   // held angles reset to zero; working registers need none
   always_ff @(posedge clock) begin
      if (reset) begin
         cur_ff <= '0;
      end else begin
         cur_ff <= cur_in;
      end
   end

   always_ff @(posedge clock) begin
      tgt_ff <= tgt_in;
      acc_ff <= acc_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      neg_ff <= neg_in;
   end

endmodule

>>> src/jsli_merge.sv
// merge stage: packs the lane points into the result register
module jsli_merge (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               push_i,
   input  jsli_pkg::angle_type                points_i [jsli_pkg::JOINTS],
   input  logic [jsli_pkg::STEP_W-1:0]        index_i,
   input  logic                               last_i,
   output logic                               free_o,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [jsli_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   output logic                               rsp_tlast
);

   logic                             valid_ff, valid_in;
   logic [jsli_pkg::RSP_DATA_W-1:0]  data_ff, data_in;
   logic                             last_ff, last_in;
   logic [jsli_pkg::RSP_DATA_W-1:0]  packed_word;

   // result register can take a new point this cycle
   assign free_o = !valid_ff || rsp_tready;

   // joints from the lowest bits, then the point index, zero pad
   always_comb begin
      packed_word = '0;
      for (int j = 0; j < jsli_pkg::JOINTS; j++) begin
         packed_word[j*jsli_pkg::ANGLE_W +: jsli_pkg::ANGLE_W] = points_i[j];
      end
      packed_word[jsli_pkg::JOINTS*jsli_pkg::ANGLE_W +: jsli_pkg::STEP_W] = index_i;
   end

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      last_in  = last_ff;
      if (push_i) begin
         valid_in = 1'b1;
         data_in  = packed_word;
         last_in  = last_i;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
      last_ff <= last_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tlast  = last_ff;

endmodule

>>> dv/joint_space_linear_interpolator_unit_tb.sv
// self-checking testbench for the joint-space linear interpolator top level
module joint_space_linear_interpolator_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   // one interpolated point as it should leave the block
   typedef struct packed {
      logic [jsli_pkg::JOINTS-1:0][jsli_pkg::ANGLE_W-1:0] joint;
      logic [jsli_pkg::STEP_W-1:0]                        index;
      logic                                               last;
   } move_point_type;

   // predicts the points of every move and checks them in order
   class jsli_scoreboard;
      jsli_pkg::angle_type         held_angle [jsli_pkg::JOINTS];
      logic [jsli_pkg::STEP_W-1:0] step_count;
      move_point_type              expected_points [$];
      int                          fail_count;

      function void clear();
         int j;
         for (j = 0; j < jsli_pkg::JOINTS; j++) held_angle[j] = '0;
         step_count = jsli_pkg::STEP_RESET;
         expected_points.delete();
         fail_count = 0;
      endfunction

      function void write_step(logic [jsli_pkg::STEP_W-1:0] value);
         step_count = value;
      endfunction

      function void flag(string what, int expected, int actual);
         if (fail_count < 10)
            $display("mismatch %s: expected %0d actual %0d", what, expected, actual);
         fail_count++;
      endfunction

      // append one expected point at the tail
      function void queue_point(move_point_type pt);
         expected_points = {expected_points, pt};
      endfunction

      // accepted target: queue up the points of the move toward it
      function void note_target(logic [jsli_pkg::REQ_DATA_W-1:0] data);
         jsli_pkg::angle_type target [jsli_pkg::JOINTS];
         int                  increment [jsli_pkg::JOINTS];
         int                  steps;
         int                  i;
         int                  j;
         bit                  same;
         move_point_type      pt;
         same = 1'b1;
         for (j = 0; j < jsli_pkg::JOINTS; j++) begin
            target[j] = data[j*jsli_pkg::ANGLE_W +: jsli_pkg::ANGLE_W];
            if (target[j] != held_angle[j]) same = 1'b0;
         end
         // target already held: one point, the target itself
         if (same) begin
            for (j = 0; j < jsli_pkg::JOINTS; j++) pt.joint[j] = target[j];
            pt.index = jsli_pkg::MIN_STEPS;
            pt.last  = 1'b1;
            queue_point(pt);
            return;
         end
         // zero counts as one, anything above the maximum saturates
         steps = int'(step_count);
         if (steps < int'(jsli_pkg::MIN_STEPS)) steps = int'(jsli_pkg::MIN_STEPS);
         if (steps > int'(jsli_pkg::MAX_STEPS)) steps = int'(jsli_pkg::MAX_STEPS);
         for (j = 0; j < jsli_pkg::JOINTS; j++)
            increment[j] = (int'(target[j]) - int'(held_angle[j])) / steps;
         for (i = 1; i <= steps; i++) begin
            for (j = 0; j < jsli_pkg::JOINTS; j++)
               pt.joint[j] = (i == steps) ? target[j] :
                             jsli_pkg::ANGLE_W'(int'(held_angle[j]) + i * increment[j]);
            pt.index = jsli_pkg::STEP_W'(i);
            pt.last  = (i == steps);
            queue_point(pt);
         end
         for (j = 0; j < jsli_pkg::JOINTS; j++) held_angle[j] = target[j];
      endfunction

      // accepted point: compare with the oldest expectation
      function void check_point(logic [jsli_pkg::RSP_DATA_W-1:0] data, logic last);
         move_point_type              want;
         logic [jsli_pkg::STEP_W-1:0] got_index;
         jsli_pkg::angle_type         got_angle;
         int                          j;
         got_index = data[jsli_pkg::JOINTS*jsli_pkg::ANGLE_W +: jsli_pkg::STEP_W];
         if (expected_points.size() == 0) begin
            if (fail_count < 10)
               $display("mismatch: point index %0d arrived with nothing expected", got_index);
            fail_count++;
            return;
         end
         want = expected_points.pop_front();
         for (j = 0; j < jsli_pkg::JOINTS; j++) begin
            got_angle = data[j*jsli_pkg::ANGLE_W +: jsli_pkg::ANGLE_W];
            if (got_angle !== jsli_pkg::angle_type'(want.joint[j]))
               flag($sformatf("joint %0d of point %0d", j, want.index),
                    int'(jsli_pkg::angle_type'(want.joint[j])), int'(got_angle));
         end
         if (got_index !== want.index)
            flag("point index", int'(want.index), int'(got_index));
         if (last !== want.last)
            flag($sformatf("last flag of point %0d", want.index), int'(want.last), int'(last));
      endfunction

      // anything still queued at the end never arrived
      function void drain_check();
         if (expected_points.size() != 0) begin
            $display("mismatch: %0d points never arrived", expected_points.size());
            fail_count += expected_points.size();
         end
      endfunction
   endclass

   logic                              clock;
   logic                              reset;
   logic                              req_tvalid;
   logic                              req_tready;
   logic [jsli_pkg::REQ_DATA_W-1:0]   req_tdata;
   logic                              rsp_tvalid;
   logic                              rsp_tready;
   logic [jsli_pkg::RSP_DATA_W-1:0]   rsp_tdata;
   logic                              rsp_tlast;
   logic                              csr_wr_en;
   logic [jsli_pkg::STEP_W-1:0]       csr_wr_data;

   jsli_scoreboard                    sb;
   logic [jsli_pkg::REQ_DATA_W-1:0]   last_target;
   bit                                steady_req;
   bit                                steady_rsp;

   joint_space_linear_interpolator_unit uut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // watchdog
   initial begin
      #8_000_000;
      $display("DONE: errors detected");
      $finish;
   end

   // transaction monitor on both channels
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) sb.check_point(rsp_tdata, rsp_tlast);
         if (req_tvalid && req_tready) sb.note_target(req_tdata);
      end
   end

   // result side: random stalls with occasional steady stretches
   initial begin
      int stall;
      steady_rsp = 1'b0;
      forever begin
         stall = steady_rsp ? 0 : $urandom_range(0, 8);
         if ($urandom_range(0, 15) == 0) steady_rsp = !steady_rsp;
         if (stall != 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!(rsp_tvalid && !reset));
      end
   end

   function automatic logic [jsli_pkg::REQ_DATA_W-1:0] joints6(int a0, int a1, int a2,
                                                               int a3, int a4, int a5);
      return {jsli_pkg::ANGLE_W'(a5), jsli_pkg::ANGLE_W'(a4), jsli_pkg::ANGLE_W'(a3),
              jsli_pkg::ANGLE_W'(a2), jsli_pkg::ANGLE_W'(a1), jsli_pkg::ANGLE_W'(a0)};
   endfunction

   // random target: mostly in range, some repeats, partial repeats,
   // small moves and full 16-bit values
   function automatic logic [jsli_pkg::REQ_DATA_W-1:0] random_target(
      logic [jsli_pkg::REQ_DATA_W-1:0] prior);
      logic [jsli_pkg::REQ_DATA_W-1:0] tgt;
      int                              kind;
      int                              j;
      kind = $urandom_range(0, 9);
      tgt  = prior;
      if (kind != 0) begin
         for (j = 0; j < jsli_pkg::JOINTS; j++) begin
            case (kind)
               1: begin
                  if ($urandom_range(0, 1) == 1)
                     tgt[j*jsli_pkg::ANGLE_W +: jsli_pkg::ANGLE_W] =
                        jsli_pkg::ANGLE_W'($urandom_range(0, 36000) - 18000);
               end
               2: tgt[j*jsli_pkg::ANGLE_W +: jsli_pkg::ANGLE_W] = jsli_pkg::ANGLE_W'($urandom);
               3: begin
                  tgt[j*jsli_pkg::ANGLE_W +: jsli_pkg::ANGLE_W] = jsli_pkg::ANGLE_W'(
                     int'(jsli_pkg::angle_type'(prior[j*jsli_pkg::ANGLE_W +: jsli_pkg::ANGLE_W]))
                     + $urandom_range(0, 40) - 20);
               end
               default: tgt[j*jsli_pkg::ANGLE_W +: jsli_pkg::ANGLE_W] =
                           jsli_pkg::ANGLE_W'($urandom_range(0, 36000) - 18000);
            endcase
         end
      end
      return tgt;
   endfunction

   // one target transaction, random gap first
   task automatic send_target(logic [jsli_pkg::REQ_DATA_W-1:0] data);
      int gap;
      gap = steady_req ? 0 : $urandom_range(0, 8);
      if ($urandom_range(0, 15) == 0) steady_req = !steady_req;
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= data;
      do @(posedge clock); while (!req_tready);
      last_target = data;
   endtask

   // wait for every expected point, let the block settle
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.expected_points.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // step count write while the block is idle
   task automatic set_steps(logic [jsli_pkg::STEP_W-1:0] value);
      wait_idle();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      sb.write_step(value);
   endtask

   // main sequence
   initial begin
      logic [jsli_pkg::STEP_W-1:0] step_pick;
      int                          phase;
      int                          n;
      sb = new();
      sb.clear();
      steady_req  = 1'b0;
      last_target = '0;
      reset       <= 1'b1;
      req_tvalid  <= 1'b0;
      req_tdata   <= '0;
      csr_wr_en   <= 1'b0;
      csr_wr_data <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // reset step count: repeat of the reset angles, extremes, partial and tiny moves
      send_target(joints6(0, 0, 0, 0, 0, 0));
      send_target(joints6(18000, 18000, 18000, 18000, 18000, 18000));
      send_target(joints6(18000, 18000, 18000, 18000, 18000, 18000));
      send_target(joints6(18000, -18000, 32767, -32768, 1, -1));
      send_target(joints6(-32768, 32767, -18000, 18000, 0, 5));
      send_target(joints6(-32768, 32767, -18000, 7, -9, 100));
      send_target(joints6(-32753, 32751, -17997, -10, 7, 99));
      send_target(joints6('h5555, 'hAAAA, 'h00FF, 'hFF00, 'h0F0F, 'hF0F0));

      // zero step count acts as one
      set_steps('0);
      send_target(joints6(100, -100, 0, 0, 0, 0));
      send_target(joints6(100, -100, 0, 0, 0, 0));

      // all ones saturates to the maximum
      set_steps('1);
      send_target(joints6(-18000, 18000, -18000, 18000, -18000, 18000));
      send_target(joints6(0, 0, 0, 0, 0, 0));

      // maximum with full-range swings
      set_steps(jsli_pkg::MAX_STEPS);
      send_target(joints6(32767, -32768, 32767, -32768, 32767, -32768));
      send_target(joints6(-32768, 32767, -32768, 32767, -32768, 32767));

      // single step
      set_steps(jsli_pkg::MIN_STEPS);
      send_target(joints6(1, 2, 3, 4, 5, 6));
      send_target(joints6(1, 2, 3, 4, 5, 6));

      // just above the maximum
      set_steps(jsli_pkg::MAX_STEPS + 7'd1);
      send_target(joints6(-5, 17, -300, 4000, -18000, 18000));

      // random phases, mostly short moves
      for (phase = 0; phase < 10; phase++) begin
         case ($urandom_range(0, 9))
            0:       step_pick = '0;
            1:       step_pick = jsli_pkg::MAX_STEPS;
            2:       step_pick = '1;
            3:       step_pick = jsli_pkg::STEP_W'($urandom_range(0, 127));
            default: step_pick = jsli_pkg::STEP_W'($urandom_range(1, 8));
         endcase
         set_steps(step_pick);
         for (n = 0; n < 15; n++) send_target(random_target(last_target));
      end

      // drain and report
      wait_idle();
      repeat (24) @(posedge clock);
      sb.drain_check();
      if (sb.fail_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
